FILE: rtl/cds_pkg.sv
// Shared types and constants for the combination difference search block.
package cds_pkg;

    localparam int VAL_W      = 40;  // line frequency and difference registers
    localparam int IDX_W      = 6;   // store index fields of a transaction
    localparam int TOL_W      = 32;  // match window half width
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int DIFF_W     = 43;  // room for a - b - difference without overflow
    localparam int MAX_OUT    = 64;  // hit results per probe
    localparam int HIT_CNT_W  = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DIFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DIFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIPLE_MODE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] line_value;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
    } t_in_item;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] value_a;
        logic signed [VAL_W-1:0] value_b;
        logic signed [VAL_W-1:0] value_c;
        logic [IDX_W-1:0]        index_c;
        logic [STATUS_W-1:0]     status;
        logic                    last;
    } t_out_item;

endpackage

FILE: rtl/cds_store.sv
// Line store: one write port, one read port with registered read data.
module cds_store import cds_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [VAL_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output logic signed [VAL_W-1:0] o_rd_data
);

    logic signed [VAL_W-1:0] r_mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/cds_match.sv
// Window test: base minus line value strictly inside plus or minus tolerance.
module cds_match import cds_pkg::*; (
    input  logic signed [DIFF_W-1:0] i_base,
    input  logic signed [VAL_W-1:0]  i_operand,
    input  logic [TOL_W-1:0]         i_tol,
    output logic                     o_in_win
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] tol_s;

    assign diff     = i_base - DIFF_W'(i_operand);
    assign tol_s    = signed'(DIFF_W'(i_tol));
    assign o_in_win = (diff < tol_s) && (diff > -tol_s);

endmodule

FILE: rtl/cds_seq.sv
// Command sequencer: loads, clears, probes and scans the store, drives results.
module cds_seq import cds_pkg::*; #(
    parameter int MAX_LINES = 64,
    parameter int AW        = 6,
    parameter int CW        = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic signed [VAL_W-1:0]  i_first_diff,
    input  logic signed [VAL_W-1:0]  i_second_diff,
    input  logic                     i_triple,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output logic                     o_rd_en,
    output logic [AW-1:0]            o_rd_addr,
    input  logic signed [VAL_W-1:0]  i_rd_data,
    output logic signed [DIFF_W-1:0] o_match_base,
    input  logic                     i_in_win
);

    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ONE  = 3'd1;
    localparam logic [2:0] S_RD_A = 3'd2;
    localparam logic [2:0] S_RD_B = 3'd3;
    localparam logic [2:0] S_PAIR = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [IDX_W-1:0]         r_ib, n_ib;
    logic signed [VAL_W-1:0]  r_va, n_va;
    logic signed [VAL_W-1:0]  r_vb, n_vb;
    logic signed [DIFF_W-1:0] r_ta1, n_ta1;
    logic signed [DIFF_W-1:0] r_ta2, n_ta2;
    logic                     r_pair, n_pair;
    logic [CW-1:0]            r_c, n_c;
    logic [CW-1:0]            r_ci, n_ci;
    logic                     r_cv, n_cv;
    logic [HIT_CNT_W-1:0]     r_nhit, n_nhit;
    t_out_item                r_pend, n_pend;
    logic                     r_pend_v, n_pend_v;
    t_out_item                r_res, n_res;
    t_out_item                r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic accept;
    logic out_free;
    logic match;
    logic stall_scan;
    logic issue;

    assign o_in_stall   = (r_state != S_IDLE);
    assign accept       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_match_base = (r_state == S_RD_B) ? r_ta1 : r_ta2;
    assign match        = r_cv && i_in_win;
    // A new hit pushes the pending one out; wait if the output is busy.
    assign stall_scan   = match && r_pend_v && !out_free;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ib        = r_ib;
        n_va        = r_va;
        n_vb        = r_vb;
        n_ta1       = r_ta1;
        n_ta2       = r_ta2;
        n_pair      = r_pair;
        n_c         = r_c;
        n_ci        = r_ci;
        n_cv        = r_cv;
        n_nhit      = r_nhit;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_wr_en     = 1'b0;
        o_wr_addr   = AW'(r_count);
        o_rd_en     = 1'b0;
        o_rd_addr   = AW'(r_c);
        issue       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_ib       = i_in_data.index_b;
                    n_state    = S_ONE;
                    unique case (i_in_data.cmd)
                        CMD_LOAD: begin
                            if (r_count < CW'(MAX_LINES)) begin
                                o_wr_en = 1'b1;
                                n_count = CW'(r_count + 1'b1);
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        CMD_PROBE: begin
                            if ((CMPW'(i_in_data.index_a) < CMPW'(r_count)) &&
                                (CMPW'(i_in_data.index_b) < CMPW'(r_count))) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(i_in_data.index_a);
                                n_state   = S_RD_A;
                            end else begin
                                n_res.status = ST_BAD_INDEX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD_A: begin
                n_va      = i_rd_data;
                n_ta1     = DIFF_W'(i_rd_data) - DIFF_W'(i_first_diff);
                n_ta2     = DIFF_W'(i_rd_data) - DIFF_W'(i_second_diff);
                o_rd_en   = 1'b1;
                o_rd_addr = AW'(r_ib);
                n_state   = S_RD_B;
            end
            S_RD_B: begin
                n_vb    = i_rd_data;
                n_pair  = i_in_win;
                n_state = S_PAIR;
            end
            S_PAIR: begin
                if (!i_triple || !r_pair) begin
                    n_res         = '0;
                    n_res.hit     = r_pair;
                    n_res.value_a = r_va;
                    n_res.value_b = r_vb;
                    n_res.last    = 1'b1;
                    n_state       = S_ONE;
                end else begin
                    n_c      = '0;
                    n_cv     = 1'b0;
                    n_nhit   = '0;
                    n_pend_v = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!stall_scan) begin
                    if (match) begin
                        if (r_pend_v) begin
                            n_out       = r_pend;
                            n_out_valid = 1'b1;
                        end
                        n_pend         = '0;
                        n_pend.hit     = 1'b1;
                        n_pend.value_a = r_va;
                        n_pend.value_b = r_vb;
                        n_pend.value_c = i_rd_data;
                        n_pend.index_c = IDX_W'(r_ci);
                        n_pend_v       = 1'b1;
                        n_nhit         = HIT_CNT_W'(r_nhit + 1'b1);
                    end
                    issue = (r_c < r_count) && (n_nhit < HIT_CNT_W'(MAX_OUT));
                    if (issue) begin
                        o_rd_en = 1'b1;
                        n_ci    = r_c;
                        n_c     = CW'(r_c + 1'b1);
                        n_cv    = 1'b1;
                    end else begin
                        n_cv    = 1'b0;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (r_pend_v) begin
                        n_out = r_pend;
                    end else begin
                        n_out         = '0;
                        n_out.value_a = r_va;
                        n_out.value_b = r_vb;
                    end
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cv        <= 1'b0;
            r_nhit      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cv        <= n_cv;
            r_nhit      <= n_nhit;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ib   <= n_ib;
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_ta1  <= n_ta1;
        r_ta2  <= n_ta2;
        r_pair <= n_pair;
        r_c    <= n_c;
        r_ci   <= n_ci;
        r_pend <= n_pend;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LINES))
        else $error("line count beyond store depth");

    a_hit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nhit <= HIT_CNT_W'(MAX_OUT))
        else $error("too many hits for one probe");

    a_scan_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_rd_en) |-> (r_c < r_count))
        else $error("scan read beyond stored lines");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("new transaction taken while one is in work");

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_IDLE && r_count < CW'(MAX_LINES)))
        else $error("store write outside a load");

endmodule

FILE: rtl/combination_difference_search.sv
// Combination difference search: top level with configuration registers.
//
// Keeps up to MAX_LINES line frequencies in a single-port-read line store and
// answers one transaction at a time. Load, clear and unused commands give a
// single result. A pair probe reads line a and line b through the one store
// read port and tests a - b - first_difference against the window. In triple
// mode a matching pair then scans the store one entry per cycle through the
// same read port, unless a new hit must wait for a busy output. Each hit is
// held in a pending register so that the final result can carry last.
// Configuration writes are taken at any time but must only be made while the
// block is idle.
module combination_difference_search import cds_pkg::*; #(
    parameter int MAX_LINES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    logic signed [VAL_W-1:0]  r_first_diff;
    logic signed [VAL_W-1:0]  r_second_diff;
    logic [TOL_W-1:0]         r_tol;
    logic                     r_triple;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [VAL_W-1:0]  rd_data;
    logic signed [DIFF_W-1:0] match_base;
    logic                     in_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_diff  <= '0;
            r_second_diff <= '0;
            r_tol         <= '0;
            r_triple      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIRST_DIFF:  r_first_diff  <= i_cfg_data;
                CFG_SECOND_DIFF: r_second_diff <= i_cfg_data;
                CFG_TOLERANCE:   r_tol         <= i_cfg_data[TOL_W-1:0];
                CFG_TRIPLE_MODE: r_triple      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    cds_store #(
        .DEPTH (MAX_LINES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.line_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cds_match u_match (
        .i_base    (match_base),
        .i_operand (rd_data),
        .i_tol     (r_tol),
        .o_in_win  (in_win)
    );

    cds_seq #(
        .MAX_LINES (MAX_LINES),
        .AW        (AW),
        .CW        (CW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_first_diff  (r_first_diff),
        .i_second_diff (r_second_diff),
        .i_triple      (r_triple),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_match_base  (match_base),
        .i_in_win      (in_win)
    );

endmodule
